@@ sv/ach_pkg.sv @@
// package for the alias categorical histogram core
// constants, payload types and the generator mixing constants; no dependencies
package ach_pkg;

    localparam int MAX_BINS = 64;
    localparam int BIN_W = $clog2(MAX_BINS);
    localparam int CNT_W = 20;
    localparam int THR_W = 54;
    localparam int D_W = 7;

    localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B = 64'h94D049BB133111EB;
    localparam logic [63:0] ROW_STRIDE = 64'd1442695040888963407;
    localparam logic [THR_W-1:0] ONE_FIXED = THR_W'(1) << 53;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [1:0] CFG_BINS = 2'd0;
    localparam logic [1:0] CFG_DRAWS = 2'd1;
    localparam logic [1:0] CFG_SEED = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_CLEAR,
        ST_DRAW,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // one draw travelling down the sampling pipeline
    typedef struct packed {
        logic             vld;
        logic [BIN_W-1:0] col;
        logic [52:0]      x2;
    } draw_t;

endpackage

@@ sv/ach_ram.sv @@
// generic single write, single registered read memory
// no dependencies
module ach_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/ach_gen.sv @@
// splitmix64 generator as a pipeline: state advance, two mixing multiplies
// split in 32-bit partial products; uses ach_pkg
module ach_gen
    import ach_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic [63:0] load_value,
    input  logic        step,
    output logic        out_vld,
    output logic [52:0] out_x,
    output logic        busy
);

    logic [63:0] state_reg;
    logic [63:0] s0_reg;
    logic        v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [63:0] a_reg, b_reg;
    logic [63:0] pa_lo_reg, pa_m1_reg, pa_m2_reg;
    logic [63:0] z1_reg;
    logic [63:0] pb_lo_reg, pb_m1_reg, pb_m2_reg;
    logic [63:0] z2_reg;
    logic [63:0] state_next;

    assign state_next = state_reg + GOLDEN_INC;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                state_reg <= load_value;
            end
            else if (step)
            begin
                state_reg <= state_next;
            end
            v0_reg <= step && !load;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_reg <= state_next;
        a_reg <= s0_reg ^ (s0_reg >> 30);
        pa_lo_reg <= {32'd0, a_reg[31:0]} * {32'd0, MIX_MUL_A[31:0]};
        pa_m1_reg <= {32'd0, a_reg[63:32]} * {32'd0, MIX_MUL_A[31:0]};
        pa_m2_reg <= {32'd0, a_reg[31:0]} * {32'd0, MIX_MUL_A[63:32]};
        z1_reg <= pa_lo_reg + {pa_m1_reg[31:0], 32'd0} + {pa_m2_reg[31:0], 32'd0};
        b_reg <= z1_reg ^ (z1_reg >> 27);
        pb_lo_reg <= {32'd0, b_reg[31:0]} * {32'd0, MIX_MUL_B[31:0]};
        pb_m1_reg <= {32'd0, b_reg[63:32]} * {32'd0, MIX_MUL_B[31:0]};
        pb_m2_reg <= {32'd0, b_reg[31:0]} * {32'd0, MIX_MUL_B[63:32]};
        z2_reg <= pb_lo_reg + {pb_m1_reg[31:0], 32'd0} + {pb_m2_reg[31:0], 32'd0};
    end

    logic [63:0] r;
    logic        v6_reg;
    logic [52:0] x_reg;

    assign r = z2_reg ^ (z2_reg >> 31);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else
        begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= r[63:11] | 53'd1;
    end

    // stage chain: s0 a pa z1 b pb z2 x
    logic v7_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else
        begin
            v7_reg <= v6_reg;
        end
    end

    assign out_vld = v7_reg;
    assign out_x = x_reg;
    assign busy = v0_reg || v1_reg || v2_reg || v3_reg || v4_reg || v5_reg
                  || v6_reg || v7_reg;

endmodule

@@ sv/ach_sampler.sv @@
// alias sampling pipeline: column multiply, table read, keep compare,
// histogram update; uses ach_pkg and ach_ram
module ach_sampler
    import ach_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tbl_we,
    input  logic [BIN_W-1:0]  tbl_addr,
    input  logic [THR_W-1:0]  tbl_thr,
    input  logic [BIN_W-1:0]  tbl_alias,
    input  logic [D_W-1:0]    d,
    input  logic              x_vld,
    input  logic [52:0]       x,
    input  logic              clr_we,
    input  logic [BIN_W-1:0]  clr_addr,
    input  logic [BIN_W-1:0]  rd_addr,
    input  logic              rd_sel,
    output logic [CNT_W-1:0]  rd_count,
    output logic              busy
);

    logic        half_reg;
    logic [52:0] x1_reg;
    logic        p0_vld_reg;
    logic [52:0] p0_x1_reg, p0_x2_reg;
    logic [59:0] prod_reg;
    logic [52:0] p1_x2_reg;
    logic        p1_vld_reg;
    logic [BIN_W-1:0] col;
    logic [6:0]  colw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= 1'b0;
            p0_vld_reg <= 1'b0;
            p1_vld_reg <= 1'b0;
        end
        else
        begin
            if (x_vld)
            begin
                half_reg <= !half_reg;
            end
            p0_vld_reg <= x_vld && half_reg;
            p1_vld_reg <= p0_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (x_vld && !half_reg)
        begin
            x1_reg <= x;
        end
        p0_x1_reg <= x1_reg;
        p0_x2_reg <= x;
        prod_reg <= 60'(p0_x1_reg) * 60'(d);
        p1_x2_reg <= p0_x2_reg;
    end

    assign colw = (prod_reg[59:53] >= d) ? d - 7'd1 : prod_reg[59:53];
    assign col = colw[BIN_W-1:0];

    logic [THR_W-1:0] thr_q;
    logic [BIN_W-1:0] alias_q;
    logic             p2_vld_reg;
    logic [BIN_W-1:0] p2_col_reg;
    logic [52:0]      p2_x2_reg;

    ach_ram #(.WIDTH(THR_W), .DEPTH(MAX_BINS)) u_thr (
        .clk(clk), .we(tbl_we), .waddr(tbl_addr), .wdata(tbl_thr),
        .raddr(col), .rdata(thr_q)
    );
    ach_ram #(.WIDTH(BIN_W), .DEPTH(MAX_BINS)) u_alias (
        .clk(clk), .we(tbl_we), .waddr(tbl_addr), .wdata(tbl_alias),
        .raddr(col), .rdata(alias_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_vld_reg <= 1'b0;
        end
        else
        begin
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_col_reg <= col;
        p2_x2_reg <= p1_x2_reg;
    end

    // category pick
    logic [BIN_W-1:0] cat_reg;
    logic             cat_ok_reg, p3_vld_reg;
    logic [BIN_W-1:0] cat_c;

    assign cat_c = ({1'b0, p2_x2_reg} < thr_q) ? p2_col_reg : alias_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_vld_reg <= 1'b0;
        end
        else
        begin
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cat_reg <= cat_c;
        cat_ok_reg <= {1'b0, cat_c} < d;
    end

    // histogram: read-modify-write with forwarding, one update a cycle
    logic [CNT_W-1:0] hist_q;
    logic             p4_vld_reg;
    logic [BIN_W-1:0] p4_cat_reg;
    logic             wb_vld_reg;
    logic [BIN_W-1:0] wb_cat_reg;
    logic [CNT_W-1:0] wb_cnt_reg;
    logic [CNT_W-1:0] cur, inc;
    logic             h_we;
    logic [BIN_W-1:0] h_waddr, h_raddr;
    logic [CNT_W-1:0] h_wdata;

    assign cur = (wb_vld_reg && wb_cat_reg == p4_cat_reg) ? wb_cnt_reg : hist_q;
    assign inc = (cur == COUNT_MAX) ? cur : cur + CNT_W'(1);
    assign h_we = clr_we || p4_vld_reg;
    assign h_waddr = clr_we ? clr_addr : p4_cat_reg;
    assign h_wdata = clr_we ? '0 : inc;
    assign h_raddr = rd_sel ? rd_addr : cat_reg;

    ach_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BINS)) u_hist (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(hist_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p4_vld_reg <= 1'b0;
            wb_vld_reg <= 1'b0;
        end
        else
        begin
            p4_vld_reg <= p3_vld_reg && cat_ok_reg;
            wb_vld_reg <= p4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p4_cat_reg <= cat_reg;
        wb_cat_reg <= p4_cat_reg;
        wb_cnt_reg <= inc;
    end

    assign rd_count = hist_q;
    assign busy = x_vld || p0_vld_reg || p1_vld_reg || p2_vld_reg || p3_vld_reg
                  || p4_vld_reg || wb_vld_reg;

endmodule

@@ sv/alias_categorical_histogram_core.sv @@
// top level of the alias categorical histogram core
// row sequencer and output register; uses ach_pkg, ach_gen, ach_sampler
//
// s_axis: request beats. tuser = req_type (0 table write, 1 row).
//   tdata = entry_index[5:0], entry_threshold[59:6], entry_alias[65:60],
//   row_index[97:66], zero padded to 104 bits.
// m_axis: one beat per category, tdata = bin_index[5:0], bin_count[25:6],
//   tlast marks the last category.
// cfg: index 0 bins_in_use, 1 draws_per_row, 2 base_seed; write when idle.
// For a row, the generator delivers one 53-bit uniform a cycle, two per
// draw, through an 8-stage mixing pipeline; a histogram clear of all 64
// bins precedes the draws, and emission reads the counts in bin order, each
// read waiting until the receiver has taken the previous beat.
// Reset clears the registers to bins 64, draws 0, seed 0, generator 0.
// A stalled receiver holds the output beat; the core waits on it.
module alias_categorical_histogram_core
    import ach_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // entry_index, entry_threshold, entry_alias, row_index
    input  logic         s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // bin_index, bin_count
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    logic [D_W-1:0]   bins_reg;
    logic [CNT_W-1:0] draws_reg;
    logic [63:0]      seed_reg;
    state_t           state_reg, state_next;
    logic [CNT_W:0]   cnt_reg, cnt_next;
    logic [D_W-1:0]   d_reg;
    logic [D_W-1:0]   d_eff;
    logic             s_acc, cfg_acc;
    logic             ovld_reg, rd_pend_reg;
    logic [BIN_W-1:0] obin_reg;
    logic             olast_reg;
    logic [CNT_W-1:0] ocnt_reg;
    logic [63:0]      row_seed;
    logic             busy;
    logic             gen_busy;
    logic [CNT_W-1:0] rd_count;
    logic             x_vld;
    logic [52:0]      x;
    logic             gen_load, gen_step, clr_we, rd_sel, tbl_we;
    logic [THR_W-1:0] thr_sat;
    logic [63:0]      rp_lo, rp_m1, rp_m2;

    assign cfg_ready = 1'b1;
    assign cfg_acc = cfg_valid && cfg_ready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign d_eff = (bins_reg == '0) ? D_W'(1)
                 : (bins_reg > D_W'(MAX_BINS)) ? D_W'(MAX_BINS) : bins_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_reg <= D_W'(MAX_BINS);
            draws_reg <= '0;
            seed_reg <= '0;
        end
        else if (cfg_acc)
        begin
            unique case (cfg_index)
                CFG_BINS: bins_reg <= cfg_data[D_W-1:0];
                CFG_DRAWS: draws_reg <= cfg_data[CNT_W-1:0];
                CFG_SEED: seed_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // row seed product in 32-bit partial products, registered in ST_SEED before the generator load
    logic [31:0] row_reg;
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            row_reg <= s_axis_tdata[97:66];
        end
        rp_lo <= {32'd0, row_reg} * {32'd0, ROW_STRIDE[31:0]};
        rp_m1 <= {32'd0, row_reg} * {32'd0, ROW_STRIDE[63:32]};
    end
    assign rp_m2 = '0;
    assign row_seed = seed_reg + rp_lo + {rp_m1[31:0], 32'd0} + rp_m2;

    assign thr_sat = (s_axis_tdata[59:6] > ONE_FIXED) ? ONE_FIXED : s_axis_tdata[59:6];
    assign tbl_we = s_acc && !s_axis_tuser;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && s_axis_tuser)
                begin
                    state_next = ST_SEED;
                    cnt_next = '0;
                end
            end
            ST_SEED:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[0])
                begin
                    state_next = ST_CLEAR;
                    cnt_next = '0;
                end
            end
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (CNT_W+1)'(MAX_BINS - 1))
                begin
                    state_next = ST_DRAW;
                    cnt_next = '0;
                end
            end
            ST_DRAW:
            begin
                if (cnt_reg == {draws_reg, 1'b0})
                begin
                    state_next = ST_DRAIN;
                    cnt_next = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!busy && !gen_busy)
                begin
                    state_next = ST_EMIT;
                    cnt_next = '0;
                end
            end
            ST_EMIT:
            begin
                if (ovld_reg && m_axis_tready && olast_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!rd_pend_reg && (!ovld_reg || m_axis_tready))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        gen_load = 1'b0;
        gen_step = 1'b0;
        clr_we = 1'b0;
        rd_sel = 1'b0;
        unique case (state_reg)
            ST_SEED: gen_load = cnt_reg[0];
            ST_CLEAR: clr_we = 1'b1;
            ST_DRAW: gen_step = (cnt_reg != {draws_reg, 1'b0});
            ST_EMIT: rd_sel = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            d_reg <= D_W'(MAX_BINS);
            ovld_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            if (s_acc && s_axis_tuser)
            begin
                d_reg <= d_eff;
            end
            if (ovld_reg && m_axis_tready)
            begin
                ovld_reg <= 1'b0;
            end
            rd_pend_reg <= 1'b0;
            if (state_reg == ST_EMIT && !rd_pend_reg && (!ovld_reg || m_axis_tready)
                && !(ovld_reg && olast_reg) && cnt_reg < (CNT_W+1)'(d_reg))
            begin
                rd_pend_reg <= 1'b1;
            end
            if (rd_pend_reg)
            begin
                ovld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && !rd_pend_reg && (!ovld_reg || m_axis_tready))
        begin
            obin_reg <= cnt_reg[BIN_W-1:0];
            olast_reg <= (cnt_reg == (CNT_W+1)'(d_reg - 7'd1));
        end
        if (rd_pend_reg)
        begin
            ocnt_reg <= rd_count;
        end
    end

    ach_gen u_gen (
        .clk(clk), .rst_n(rst_n), .load(gen_load), .load_value(row_seed),
        .step(gen_step), .out_vld(x_vld), .out_x(x), .busy(gen_busy)
    );

    ach_sampler u_smp (
        .clk(clk), .rst_n(rst_n), .tbl_we(tbl_we),
        .tbl_addr(s_axis_tdata[5:0]), .tbl_thr(thr_sat),
        .tbl_alias(s_axis_tdata[65:60]), .d(d_reg), .x_vld(x_vld), .x(x),
        .clr_we(clr_we), .clr_addr(cnt_reg[BIN_W-1:0]),
        .rd_addr(cnt_reg[BIN_W-1:0]), .rd_sel(rd_sel), .rd_count(rd_count),
        .busy(busy)
    );

    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata = {6'd0, ocnt_reg, obin_reg};
    assign m_axis_tlast = olast_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken while results pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat dropped under stall");
    a_no_gen_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> !busy && !gen_busy)
        else $error("draws still in flight during emission");

endmodule
